FILE: rtl/core/dshot_ft_pkg.sv
// ----------------------------------------------------------------------------
// DShot frame transmitter package
// Shared types, register indexes, item codes and the frame encoder.
// ----------------------------------------------------------------------------
package dshot_ft_pkg;

  localparam int unsigned DefaultChannels = 4;
  localparam int unsigned PinW            = 4;
  localparam int unsigned FrameW          = 16;
  localparam int unsigned ThrottleW       = 11;
  localparam int unsigned CfgIndexW       = 3;
  localparam int unsigned CfgDataW        = 16;

  localparam logic [CfgIndexW-1:0] RegBitPeriod    = 3'd0;
  localparam logic [CfgIndexW-1:0] RegZeroHigh     = 3'd1;
  localparam logic [CfgIndexW-1:0] RegOneHigh      = 3'd2;
  localparam logic [CfgIndexW-1:0] RegActiveMask   = 3'd3;
  localparam logic [CfgIndexW-1:0] RegArmed        = 3'd4;

  localparam logic [1:0] FuncSetData = 2'd0;
  localparam logic [1:0] FuncTrigger = 2'd1;
  localparam logic [1:0] FuncTick    = 2'd2;

  localparam logic [15:0] BitPeriodReset = 16'd166;
  localparam logic [15:0] ZeroHighReset  = 16'd62;
  localparam logic [15:0] OneHighReset   = 16'd124;

  typedef struct packed {
    logic [1:0]           func;
    logic [1:0]           motor_index;
    logic [ThrottleW-1:0] throttle;
    logic                 telem_req;
  } in_item_t;

  typedef struct packed {
    logic [PinW-1:0] pin_levels;
    logic            busy_res;
    logic            frame_done;
  } out_item_t;

  typedef struct packed {
    logic [15:0]     period_ticks;
    logic [15:0]     zero_high;
    logic [15:0]     one_high;
    logic [PinW-1:0] active_mask;
    logic            armed;
  } seq_cfg_t;

  typedef struct packed {
    logic trigger;
    logic tick;
    logic abort;
  } seq_ctrl_t;

  typedef struct packed {
    logic [PinW-1:0] pins;
    logic            busy;
    logic            done;
  } seq_status_t;

  function automatic logic [FrameW-1:0] make_frame(logic [ThrottleW-1:0] thr, logic tel);
    logic [11:0] payload;
    logic [3:0]  csum;
    payload = {thr, tel};
    csum    = payload[3:0] ^ payload[7:4] ^ payload[11:8];
    return {payload, csum};
  endfunction

endpackage

FILE: rtl/core/dshot_frame_transmitter_unit.sv
// ----------------------------------------------------------------------------
// DShot frame transmitter unit
// A result is valid in the cycle after its item transfers; one item per cycle unless stalled.
// Each item is processed at its transfer and its result is held in an output
// register; while a result waits, a new item is taken only in the cycle in
// which that result transfers.
// Reset clears the registers to their defaults, the throttles and the timer.
// ----------------------------------------------------------------------------
module dshot_frame_transmitter_unit #(
  parameter int unsigned Channels = dshot_ft_pkg::DefaultChannels
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  dshot_ft_pkg::in_item_t               in_data_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output dshot_ft_pkg::out_item_t              out_data_o,
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [dshot_ft_pkg::CfgIndexW-1:0]   cfg_index_i,
  input  logic [dshot_ft_pkg::CfgDataW-1:0]    cfg_data_i
);

  localparam int unsigned Lanes = (Channels < dshot_ft_pkg::PinW) ? Channels
                                                                   : dshot_ft_pkg::PinW;

  dshot_ft_pkg::seq_cfg_t    cfg_q;
  dshot_ft_pkg::seq_ctrl_t   ctrl;
  dshot_ft_pkg::seq_status_t status;
  dshot_ft_pkg::out_item_t   out_data_q;

  logic [Lanes-1:0][dshot_ft_pkg::ThrottleW-1:0] throttle_q;
  logic [Lanes-1:0]                              telem_q;
  logic [Lanes-1:0][dshot_ft_pkg::FrameW-1:0]    frames;

  logic out_valid_q;
  logic in_fire;
  logic cfg_fire;
  logic arm_write;
  logic set_data;

  assign in_ready_o  = !out_valid_q || out_ready_i;
  assign in_fire     = in_valid_i && in_ready_o;
  assign cfg_ready_o = 1'b1;
  assign cfg_fire    = cfg_valid_i;
  assign arm_write   = cfg_fire && (cfg_index_i == dshot_ft_pkg::RegArmed);
  assign set_data    = in_fire && (in_data_i.func == dshot_ft_pkg::FuncSetData);

  assign ctrl.trigger = in_fire && (in_data_i.func == dshot_ft_pkg::FuncTrigger);
  assign ctrl.tick    = in_fire && (in_data_i.func == dshot_ft_pkg::FuncTick);
  assign ctrl.abort   = arm_write && !cfg_data_i[0];

  always_comb begin
    for (int i = 0; i < Lanes; i++) begin
      frames[i] = dshot_ft_pkg::make_frame(throttle_q[i], telem_q[i]);
    end
  end

  dshot_ft_sequencer #(
    .Lanes(Lanes)
  ) u_sequencer (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (ctrl),
    .cfg_i   (cfg_q),
    .frames_i(frames),
    .status_o(status)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.period_ticks <= dshot_ft_pkg::BitPeriodReset;
      cfg_q.zero_high    <= dshot_ft_pkg::ZeroHighReset;
      cfg_q.one_high     <= dshot_ft_pkg::OneHighReset;
      cfg_q.active_mask  <= '0;
      cfg_q.armed        <= 1'b0;
    end else if (cfg_fire) begin
      unique case (cfg_index_i)
        dshot_ft_pkg::RegBitPeriod:  cfg_q.period_ticks <= cfg_data_i;
        dshot_ft_pkg::RegZeroHigh:   cfg_q.zero_high    <= cfg_data_i;
        dshot_ft_pkg::RegOneHigh:    cfg_q.one_high     <= cfg_data_i;
        dshot_ft_pkg::RegActiveMask: cfg_q.active_mask  <= cfg_data_i[dshot_ft_pkg::PinW-1:0];
        dshot_ft_pkg::RegArmed:      cfg_q.armed        <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      throttle_q <= '0;
      telem_q    <= '0;
    end else begin
      for (int i = 0; i < Lanes; i++) begin
        if (set_data && cfg_q.active_mask[i] && (in_data_i.motor_index == 2'(i))) begin
          throttle_q[i] <= in_data_i.throttle;
          telem_q[i]    <= in_data_i.telem_req;
        end
        if (arm_write && cfg_q.active_mask[i]) begin
          throttle_q[i] <= '0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      out_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      out_data_q.pin_levels <= status.pins;
      out_data_q.busy_res   <= status.busy;
      out_data_q.frame_done <= status.done;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

FILE: rtl/core/dshot_ft_sequencer.sv
// ----------------------------------------------------------------------------
// DShot frame sequencer
// Holds the encoded frame words and the bit timer, and drives the pin levels.
// ----------------------------------------------------------------------------
module dshot_ft_sequencer #(
  parameter int unsigned Lanes = dshot_ft_pkg::DefaultChannels
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  dshot_ft_pkg::seq_ctrl_t               ctrl_i,
  input  dshot_ft_pkg::seq_cfg_t                cfg_i,
  input  logic [Lanes-1:0][dshot_ft_pkg::FrameW-1:0] frames_i,
  output dshot_ft_pkg::seq_status_t             status_o
);

  logic [Lanes-1:0][dshot_ft_pkg::FrameW-1:0] frame_q;
  logic [15:0] tick_q, tick_d;
  logic [4:0]  slot_q, slot_d;
  logic        send_q, send_d;
  logic        start;
  logic        in_data_slot;
  logic [4:0]  pos_full;
  logic [3:0]  pos;
  logic        period_end;

  assign start        = ctrl_i.trigger && cfg_i.armed && !send_q;
  assign in_data_slot = (slot_q >= 5'd1) && (slot_q <= 5'd16);
  assign pos_full     = 5'd16 - slot_q;
  assign pos          = pos_full[3:0];
  assign period_end   = ({1'b0, tick_q} + 17'd1) >= {1'b0, cfg_i.period_ticks};

  always_comb begin
    tick_d        = tick_q;
    slot_d        = slot_q;
    send_d        = send_q;
    status_o.pins = '0;
    status_o.done = 1'b0;
    if (start) begin
      send_d = 1'b1;
      tick_d = '0;
      slot_d = '0;
    end else if (ctrl_i.tick && send_q) begin
      if (in_data_slot) begin
        for (int i = 0; i < Lanes; i++) begin
          if (cfg_i.active_mask[i]) begin
            if (frame_q[i][pos]) begin
              status_o.pins[i] = tick_q < cfg_i.one_high;
            end else begin
              status_o.pins[i] = tick_q < cfg_i.zero_high;
            end
          end
        end
      end
      if (period_end) begin
        tick_d = '0;
        if (slot_q >= 5'd16) begin
          slot_d        = '0;
          send_d        = 1'b0;
          status_o.done = 1'b1;
        end else begin
          slot_d = slot_q + 5'd1;
        end
      end else begin
        tick_d = tick_q + 16'd1;
      end
    end
    if (ctrl_i.abort) begin
      send_d = 1'b0;
      tick_d = '0;
      slot_d = '0;
    end
    status_o.busy = send_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tick_q <= '0;
      slot_q <= '0;
      send_q <= 1'b0;
    end else begin
      tick_q <= tick_d;
      slot_q <= slot_d;
      send_q <= send_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start) begin
      for (int i = 0; i < Lanes; i++) begin
        if (cfg_i.active_mask[i]) begin
          frame_q[i] <= frames_i[i];
        end
      end
    end
  end

endmodule
